// ----- src/mi4_pkg.sv -----
// Shared types, widths and the cofactor step table for the 4x4 matrix inverse.
`timescale 1ns / 1ps
package mi4_pkg;

	// Element width and the default number of fraction bits.
	localparam int E_W = 32;
	localparam int FRAC_BITS_DEF = 16;

	// Widths of the intermediate values.
	localparam int T_W = 66;   // 2x2 minor
	localparam int M_W = 98;   // 3x3 cofactor
	localparam int D_W = 131;  // determinant
	localparam int P_W = 164;  // product, numerator and shifted divisor

	// Depth of the row queue between the front and the back.
	localparam int Q_DEPTH = 2;
	localparam int Q_AW = $clog2(Q_DEPTH);

	// Multiplicand sources.
	localparam logic [1:0] WS_ELEM = 2'd0;
	localparam logic [1:0] WS_T    = 2'd1;
	localparam logic [1:0] WS_M    = 2'd2;

	// Accumulation targets.
	localparam logic [1:0] TG_T = 2'd0;
	localparam logic [1:0] TG_M = 2'd1;
	localparam logic [1:0] TG_D = 2'd2;

	// Step index of the determinant product.
	localparam logic [3:0] K_DET = 4'd9;
	localparam logic [3:0] K_LAST_COF = 4'd8;

	// One queued matrix row with its position in the matrix.
	typedef struct packed {
		logic [3:0][E_W-1:0] elem;
		logic [1:0]          row;
		logic                last;
	} row_word_t;

	// Fill status of the row queue.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// One multiply-accumulate step.
	typedef struct packed {
		logic [3:0] mr_addr;
		logic [3:0] w_addr;
		logic [1:0] w_sel;
		logic [1:0] tgt;
		logic       sub;
		logic       clr;
	} uop_t;

	// Index n of the three indices that remain once x is removed.
	function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] x);
		return (n >= x) ? n + 2'd1 : n;
	endfunction

	// Step k of the cofactor of element (sr, sc); step nine adds e(0,sc) times
	// the cofactor into the determinant.
	function automatic uop_t cof_uop(input logic [1:0] sr, input logic [1:0] sc,
			input logic [3:0] k);
		uop_t u;
		logic [1:0] r0, r1, r2, c0, c1, c2, a, b, cg, g, s;
		logic odd;
		r0 = skip_idx(2'd0, sr);
		r1 = skip_idx(2'd1, sr);
		r2 = skip_idx(2'd2, sr);
		c0 = skip_idx(2'd0, sc);
		c1 = skip_idx(2'd1, sc);
		c2 = skip_idx(2'd2, sc);
		odd = sr[0] ^ sc[0];
		case (k)
			4'd0: begin g = 2'd0; s = 2'd0; end
			4'd1: begin g = 2'd0; s = 2'd1; end
			4'd2: begin g = 2'd0; s = 2'd2; end
			4'd3: begin g = 2'd1; s = 2'd0; end
			4'd4: begin g = 2'd1; s = 2'd1; end
			4'd5: begin g = 2'd1; s = 2'd2; end
			4'd6: begin g = 2'd2; s = 2'd0; end
			4'd7: begin g = 2'd2; s = 2'd1; end
			default: begin g = 2'd2; s = 2'd2; end
		endcase
		case (g)
			2'd0: begin a = c1; b = c2; cg = c0; end
			2'd1: begin a = c0; b = c2; cg = c1; end
			default: begin a = c0; b = c1; cg = c2; end
		endcase
		u = '0;
		case (s)
			2'd0: begin
				u.mr_addr = {r1, a};
				u.w_addr  = {r2, b};
				u.w_sel   = WS_ELEM;
				u.tgt     = TG_T;
				u.clr     = 1'b1;
			end
			2'd1: begin
				u.mr_addr = {r1, b};
				u.w_addr  = {r2, a};
				u.w_sel   = WS_ELEM;
				u.tgt     = TG_T;
				u.sub     = 1'b1;
			end
			default: begin
				u.mr_addr = {r0, cg};
				u.w_sel   = WS_T;
				u.tgt     = TG_M;
				u.sub     = (g == 2'd1) ^ odd;
				u.clr     = (g == 2'd0);
			end
		endcase
		if (k == K_DET) begin
			u = '0;
			u.mr_addr = {2'd0, sc};
			u.w_sel   = WS_M;
			u.tgt     = TG_D;
			u.clr     = (sc == 2'd0);
		end
		return u;
	endfunction

endpackage

// ----- src/mi4_if.sv -----
// Valid-ready channel interfaces for matrix rows and inverse rows.
`timescale 1ns / 1ps
interface mi4_row_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] in_c0;
	logic signed [31:0] in_c1;
	logic signed [31:0] in_c2;
	logic signed [31:0] in_c3;
	modport source(output valid, in_c0, in_c1, in_c2, in_c3, input ready);
	modport sink(input valid, in_c0, in_c1, in_c2, in_c3, output ready);
endinterface

interface mi4_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] res_c0;
	logic signed [31:0] res_c1;
	logic signed [31:0] res_c2;
	logic signed [31:0] res_c3;
	logic               singular;
	logic               last_row;
	modport source(output valid, res_c0, res_c1, res_c2, res_c3, singular, last_row,
		input ready);
	modport sink(input valid, res_c0, res_c1, res_c2, res_c3, singular, last_row,
		output ready);
endinterface

// ----- src/matrix_inverse_4x4.sv -----
// Top level of the streaming 4x4 matrix inverse (adjugate over determinant).
//
//   channel | dir | word                      | last mark
//   rows    | in  | one matrix row, Q16.16    | fourth row completes a matrix
//   inv     | out | one inverse row, Q16.16   | last_row on the fourth result
//
// Rows are taken into a two-word queue while it has room.
// The fourth row starts the back part: every product runs through one shared
// 32-step shift-add multiplier; the determinant takes 40 products, each of
// the 16 inverse elements 9 products and a 33-step divider. A singular
// matrix ends after the determinant. Reset clears all control state; the
// row store is written before it is read. While the back part is busy the
// queue takes up to two more rows, then rows stalls; a result word held by
// inv stalls the back part.
`timescale 1ns / 1ps
module matrix_inverse_4x4
	import mi4_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mi4_row_if.sink   rows,
	mi4_res_if.source inv
);

	q_stat_t   qs;
	logic      push;
	row_word_t push_word;
	logic      pop;
	row_word_t pop_word;

	mi4_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rows      (rows),
		.qs        (qs),
		.push      (push),
		.push_word (push_word)
	);

	mi4_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.qs        (qs)
	);

	mi4_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qs       (qs),
		.pop_word (pop_word),
		.pop      (pop),
		.inv      (inv)
	);

	// A singular result row carries only zeros.
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid && inv.singular |->
			inv.res_c0 == 0 && inv.res_c1 == 0 && inv.res_c2 == 0 && inv.res_c3 == 0)
		else $error("singular row with nonzero elements");

	// After the last row of a matrix leaves, no result follows at once.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		inv.valid && inv.ready && inv.last_row |=> !inv.valid)
		else $error("result word right after the last row");

	// The queue status is never both full and empty.
	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		qs.full |-> !qs.empty)
		else $error("queue full and empty at once");

endmodule

// ----- src/mi4_front.sv -----
// Front part: accepts matrix rows and tags each with its row position.
`timescale 1ns / 1ps
module mi4_front
	import mi4_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	mi4_row_if.sink   rows,
	input  q_stat_t   qs,
	output logic      push,
	output row_word_t push_word
);

	logic [1:0] row_q;

	// A row is taken whenever the queue has room.
	assign rows.ready = !qs.full;
	assign push = rows.valid && rows.ready;

	// Tag the word with its row and mark the row that completes the matrix.
	always_comb begin
		push_word.elem[0] = rows.in_c0;
		push_word.elem[1] = rows.in_c1;
		push_word.elem[2] = rows.in_c2;
		push_word.elem[3] = rows.in_c3;
		push_word.row     = row_q;
		push_word.last    = (row_q == 2'd3);
	end

	// Count rows loaded; wraps after the fourth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 2'd0;
		end else if (push) begin
			row_q <= row_q + 2'd1;
		end
	end

endmodule

// ----- src/mi4_fifo.sv -----
// Short row queue between the front and the back.
`timescale 1ns / 1ps
module mi4_fifo
	import mi4_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  row_word_t push_word,
	input  logic      pop,
	output row_word_t pop_word,
	output q_stat_t   qs
);

	row_word_t       mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q;
	logic [Q_AW-1:0] rp_q;
	logic [Q_AW:0]   cnt_q;

	assign qs.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign qs.empty = (cnt_q == '0);
	assign pop_word = mem_q[rp_q];

	// Storage for queued words.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/mi4_back.sv -----
// Back part: stores rows, computes the determinant and adjugate with one serial
// multiplier, divides with a restoring divider and drives the result register.
`timescale 1ns / 1ps
module mi4_back
	import mi4_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  q_stat_t   qs,
	input  row_word_t pop_word,
	output logic      pop,
	mi4_res_if.source inv
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LDM  = 4'd1;
	localparam logic [3:0] S_LDW  = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_COM  = 4'd4;
	localparam logic [3:0] S_CHK  = 4'd5;
	localparam logic [3:0] S_DIVI = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0] state_q;
	logic       dm_q;      // determinant phase
	logic [1:0] c_q;       // determinant column
	logic [1:0] i_q;       // result row
	logic [1:0] j_q;       // result column
	logic [3:0] k_q;       // step within a cofactor
	logic [5:0] cnt_q;
	logic       sing_q;
	logic       high_q;
	logic       ov_q;

	logic [E_W-1:0]  store_q [16];
	logic [E_W-1:0]  mr_q;
	logic [P_W-1:0]  mc_q;
	logic [P_W-1:0]  prod_q;
	logic [T_W-1:0]  t_q;
	logic [M_W-1:0]  m_q;
	logic [D_W-1:0]  det_q;
	logic [P_W-1:0]  r_q;
	logic [P_W-1:0]  dv_q;
	logic [31:0]     q_q;
	logic [31:0]     rb_q [4];
	logic [31:0]     res_q [4];
	logic            sing_out_q;
	logic            last_q;

	uop_t           u;
	logic [1:0]     cof_r;
	logic [1:0]     cof_c;
	logic [3:0]     rd_addr;
	logic [E_W-1:0] rd;
	logic           mneg;
	logic [P_W-1:0] maddend;
	logic [P_W-1:0] cur;
	logic [P_W-1:0] csum;
	logic [P_W:0]   diff;
	logic           ge;
	logic [M_W-1:0] absm;
	logic [D_W-1:0] absd;
	logic           qneg;
	logic [31:0]    sat;
	logic           out_load;

	// Current cofactor and step.
	assign cof_r = dm_q ? 2'd0 : j_q;
	assign cof_c = dm_q ? c_q : i_q;
	assign u = cof_uop(cof_r, cof_c, k_q);

	// One read of the matrix store per cycle.
	assign rd_addr = (state_q == S_LDW) ? u.w_addr : u.mr_addr;
	assign rd = store_q[rd_addr];

	assign pop = (state_q == S_IDLE) && !qs.empty;

	// Shift-add multiplier: the sign bit of the multiplier carries negative weight.
	assign mneg = (cnt_q == 6'd31);
	assign maddend = mc_q ^ {P_W{mneg}};

	// Commit of a finished product into its target.
	always_comb begin
		case (u.tgt)
			TG_T: cur = {{(P_W-T_W){t_q[T_W-1]}}, t_q};
			TG_M: cur = {{(P_W-M_W){m_q[M_W-1]}}, m_q};
			default: cur = {{(P_W-D_W){det_q[D_W-1]}}, det_q};
		endcase
		if (u.clr) begin
			cur = '0;
		end
		csum = cur + (prod_q ^ {P_W{u.sub}}) + P_W'(u.sub);
	end

	// Restoring division step and operand magnitudes.
	assign diff = {1'b0, r_q} - {1'b0, dv_q};
	assign ge = !diff[P_W];
	assign absm = m_q[M_W-1] ? M_W'(-m_q) : m_q;
	assign absd = det_q[D_W-1] ? D_W'(-det_q) : det_q;

	// Saturate the quotient to the signed 32-bit range.
	always_comb begin
		qneg = m_q[M_W-1] ^ det_q[D_W-1];
		if (qneg) begin
			sat = (high_q || q_q > 32'h8000_0000) ? 32'h8000_0000 : 32'(32'd0 - q_q);
		end else begin
			sat = (high_q || q_q[31]) ? 32'h7FFF_FFFF : q_q;
		end
	end

	assign out_load = (state_q == S_OUT) && (!ov_q || inv.ready);

	// Result valid: set on a load, cleared once the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (inv.ready) begin
			ov_q <= 1'b0;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dm_q    <= 1'b0;
			c_q     <= 2'd0;
			i_q     <= 2'd0;
			j_q     <= 2'd0;
			k_q     <= 4'd0;
			cnt_q   <= 6'd0;
			sing_q  <= 1'b0;
			high_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop && pop_word.last) begin
						dm_q    <= 1'b1;
						c_q     <= 2'd0;
						k_q     <= 4'd0;
						sing_q  <= 1'b0;
						state_q <= S_LDM;
					end
				end
				S_LDM: begin
					cnt_q   <= 6'd0;
					state_q <= S_LDW;
				end
				S_LDW: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= S_COM;
					end
				end
				S_COM: begin
					if (k_q == K_DET) begin
						k_q <= 4'd0;
						if (c_q == 2'd3) begin
							state_q <= S_CHK;
						end else begin
							c_q     <= c_q + 2'd1;
							state_q <= S_LDM;
						end
					end else if (k_q == K_LAST_COF) begin
						if (dm_q) begin
							k_q     <= K_DET;
							state_q <= S_LDM;
						end else begin
							state_q <= S_DIVI;
						end
					end else begin
						k_q     <= k_q + 4'd1;
						state_q <= S_LDM;
					end
				end
				S_CHK: begin
					dm_q <= 1'b0;
					i_q  <= 2'd0;
					j_q  <= 2'd0;
					k_q  <= 4'd0;
					if (det_q == '0) begin
						sing_q  <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_LDM;
					end
				end
				S_DIVI: begin
					cnt_q   <= 6'd0;
					high_q  <= 1'b0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd0) begin
						high_q <= ge;
					end
					if (cnt_q == 6'd32) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					k_q <= 4'd0;
					if (j_q == 2'd3) begin
						state_q <= S_OUT;
					end else begin
						j_q     <= j_q + 2'd1;
						state_q <= S_LDM;
					end
				end
				S_OUT: begin
					if (out_load) begin
						j_q  <= 2'd0;
						k_q  <= 4'd0;
						if (i_q == 2'd3) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + 2'd1;
							state_q <= sing_q ? S_OUT : S_LDM;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int c = 0; c < 4; c++) begin
				store_q[{pop_word.row, 2'(c)}] <= pop_word.elem[c];
			end
		end
		case (state_q)
			S_LDM: begin
				mr_q   <= rd;
				prod_q <= '0;
			end
			S_LDW: begin
				case (u.w_sel)
					WS_ELEM: mc_q <= {{(P_W-E_W){rd[E_W-1]}}, rd};
					WS_T: mc_q <= {{(P_W-T_W){t_q[T_W-1]}}, t_q};
					default: mc_q <= {{(P_W-M_W){m_q[M_W-1]}}, m_q};
				endcase
			end
			S_MUL: begin
				if (mr_q[0]) begin
					prod_q <= prod_q + maddend + P_W'(mneg);
				end
				mr_q <= mr_q >> 1;
				mc_q <= mc_q << 1;
			end
			S_COM: begin
				case (u.tgt)
					TG_T: t_q <= csum[T_W-1:0];
					TG_M: m_q <= csum[M_W-1:0];
					default: det_q <= csum[D_W-1:0];
				endcase
			end
			S_DIVI: begin
				r_q  <= {{(P_W-M_W){1'b0}}, absm} << (2 * FRAC_BITS);
				dv_q <= {{(P_W-D_W){1'b0}}, absd} << 32;
				q_q  <= '0;
			end
			S_DIV: begin
				if (cnt_q != 6'd0) begin
					q_q <= {q_q[30:0], ge};
					if (ge) begin
						r_q <= diff[P_W-1:0];
					end
				end
				dv_q <= dv_q >> 1;
			end
			S_FIN: begin
				rb_q[j_q] <= sat;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			for (int c = 0; c < 4; c++) begin
				res_q[c] <= sing_q ? 32'd0 : rb_q[c];
			end
			sing_out_q <= sing_q;
			last_q     <= (i_q == 2'd3);
		end
	end

	assign inv.valid    = ov_q;
	assign inv.res_c0   = res_q[0];
	assign inv.res_c1   = res_q[1];
	assign inv.res_c2   = res_q[2];
	assign inv.res_c3   = res_q[3];
	assign inv.singular = sing_out_q;
	assign inv.last_row = last_q;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the streaming 4x4 matrix inverse.
`timescale 1ns / 1ps
module tb_top
	import mi4_pkg::*;
;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint CYCLE_LIMIT = 64'd6000000;

	typedef logic signed [191:0] wide_t;

	// One matrix row as driven, and one inverse row as expected.
	typedef struct {
		logic [31:0] c [4];
	} row_t;

	typedef struct {
		logic [31:0] c [4];
		logic        sing;
		logic        last;
	} inv_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mi4_row_if rows ();
	mi4_res_if inv ();

	matrix_inverse_4x4 #(.FRAC_BITS(FRAC)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rows(rows.sink),
		.inv(inv.source)
	);

	// Free-running clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	row_t      pending_rows [$];
	inv_row_t  expected_inv [$];
	logic [31:0] mat [16];
	int        row_pos = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	bit        hold_send = 1'b0;
	int        errors = 0;
	int        words_in = 0;
	int        words_out = 0;
	int        singular_seen = 0;
	int        sat_seen = 0;
	longint    cycles = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("MISMATCH at inverse row %0d: %s got %h expected %h",
			words_out, what, got, want);
	endtask

	function automatic wide_t el(input int r, input int c);
		return wide_t'($signed(mat[r * 4 + c]));
	endfunction

	// Signed cofactor of element (sr, sc) of the stored matrix.
	function automatic wide_t cofactor_of(input int sr, input int sc);
		int rw [3];
		int cl [3];
		int n;
		wide_t t0, t1, t2, m;
		n = 0;
		for (int i = 0; i < 4; i++) if (i != sr) rw[n++] = i;
		n = 0;
		for (int i = 0; i < 4; i++) if (i != sc) cl[n++] = i;
		t0 = el(rw[1], cl[1]) * el(rw[2], cl[2]) - el(rw[1], cl[2]) * el(rw[2], cl[1]);
		t1 = el(rw[1], cl[0]) * el(rw[2], cl[2]) - el(rw[1], cl[2]) * el(rw[2], cl[0]);
		t2 = el(rw[1], cl[0]) * el(rw[2], cl[1]) - el(rw[1], cl[1]) * el(rw[2], cl[0]);
		m = el(rw[0], cl[0]) * t0 - el(rw[0], cl[1]) * t1 + el(rw[0], cl[2]) * t2;
		return ((sr + sc) % 2 == 1) ? -m : m;
	endfunction

	// Truncating division with saturation to the signed 32-bit range.
	function automatic logic [31:0] divide_saturate(input wide_t num, input wide_t den);
		logic neg;
		wide_t q;
		neg = num[191] ^ den[191];
		q = (num[191] ? -num : num) / (den[191] ? -den : den);
		if (neg) begin
			if (q > 192'sh80000000) return 32'h80000000;
			return 32'(-q);
		end
		if (q >= 192'sh80000000) return 32'h7FFFFFFF;
		return q[31:0];
	endfunction

	// Stores one accepted row; the fourth row produces the four inverse rows.
	task automatic store_row_and_invert(input row_t r);
		wide_t cof [4][4];
		wide_t det;
		inv_row_t e;
		for (int c = 0; c < 4; c++) mat[row_pos * 4 + c] = r.c[c];
		if (row_pos != 3) begin
			row_pos++;
			return;
		end
		row_pos = 0;
		det = '0;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) cof[i][j] = cofactor_of(i, j);
		for (int c = 0; c < 4; c++) det += el(0, c) * cof[0][c];
		if (det == 0) singular_seen++;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				e.c[j] = 32'd0;
				if (det != 0) e.c[j] = divide_saturate(cof[j][i] <<< (2 * FRAC), det);
				if (e.c[j] == 32'h7FFFFFFF || e.c[j] == 32'h80000000) sat_seen++;
			end
			e.sing = (det == 0);
			e.last = (i == 3);
			expected_inv.insert(expected_inv.size(), e);
		end
	endtask

	// Driver: presents queued rows and counts accepted words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows.valid <= 1'b0;
			rows.in_c0 <= '0;
			rows.in_c1 <= '0;
			rows.in_c2 <= '0;
			rows.in_c3 <= '0;
		end else begin
			if (rows.valid && rows.ready) begin
				store_row_and_invert(pending_rows.pop_front());
				words_in++;
			end
			if (!(rows.valid && !rows.ready)) begin
				if (pending_rows.size() > 0 && !hold_send &&
						$urandom_range(99) >= send_idle_pct) begin
					rows.valid <= 1'b1;
					rows.in_c0 <= pending_rows[0].c[0];
					rows.in_c1 <= pending_rows[0].c[1];
					rows.in_c2 <= pending_rows[0].c[2];
					rows.in_c3 <= pending_rows[0].c[3];
				end else begin
					rows.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random back-pressure and field-by-field comparison.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv.ready <= 1'b0;
		end else begin
			if (inv.valid && inv.ready) begin
				if (expected_inv.size() == 0) begin
					errors++;
					$display("MISMATCH: inverse row with nothing expected");
				end else begin
					inv_row_t e;
					e = expected_inv.pop_front();
					if (inv.res_c0 !== e.c[0]) report_mismatch("res_c0", inv.res_c0, e.c[0]);
					if (inv.res_c1 !== e.c[1]) report_mismatch("res_c1", inv.res_c1, e.c[1]);
					if (inv.res_c2 !== e.c[2]) report_mismatch("res_c2", inv.res_c2, e.c[2]);
					if (inv.res_c3 !== e.c[3]) report_mismatch("res_c3", inv.res_c3, e.c[3]);
					if (inv.singular !== e.sing)
						report_mismatch("singular", inv.singular, e.sing);
					if (inv.last_row !== e.last)
						report_mismatch("last_row", inv.last_row, e.last);
				end
				words_out++;
			end
			inv.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Cycle counter with a hard limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic logic [31:0] rand_elem(input int kind);
		case (kind)
			0: return $urandom();
			1: return 32'($signed($urandom_range(8 << FRAC, 0)) - (4 << FRAC));
			2: return 32'($signed($urandom_range(64, 0)) - 32);
			default: return $urandom_range(3) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
		endcase
	endfunction

	task automatic queue_matrix(input logic [31:0] m [16]);
		row_t r;
		for (int i = 0; i < 4; i++) begin
			for (int c = 0; c < 4; c++) r.c[c] = m[i * 4 + c];
			pending_rows.insert(pending_rows.size(), r);
		end
	endtask

	task automatic queue_random_matrix();
		logic [31:0] m [16];
		int kind;
		kind = $urandom_range(9);
		for (int i = 0; i < 16; i++) begin
			if (kind < 5) m[i] = rand_elem(1);
			else if (kind < 7) m[i] = rand_elem(2);
			else if (kind < 8) m[i] = rand_elem(0);
			else m[i] = rand_elem($urandom_range(3));
		end
		// Now and then force a singular matrix by copying a row.
		if ($urandom_range(7) == 0)
			for (int c = 0; c < 4; c++) m[12 + c] = m[$urandom_range(2) * 4 + c];
		queue_matrix(m);
	endtask

	task automatic drain();
		while (pending_rows.size() > 0 || expected_inv.size() > 0) @(posedge clk);
	endtask

	initial begin
		logic [31:0] m [16];
		int phase_pct [4][2];
		phase_pct = '{'{0, 0}, '{81, 0}, '{0, 81}, '{9, 9}};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: identity, scaled diagonal, zero, extremes, tiny values.
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h00010000 : 32'h0;
		queue_matrix(m);
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'hFFFE0000 : 32'h0;
		queue_matrix(m);
		for (int i = 0; i < 16; i++) m[i] = 32'h0;
		queue_matrix(m);
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h00000001 : 32'h0;
		queue_matrix(m);
		for (int i = 0; i < 16; i++)
			m[i] = (i % 5 == 0) ? 32'h80000000 : ((i % 3 == 0) ? 32'h7FFFFFFF : 32'h0);
		queue_matrix(m);
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h7FFFFFFF : 32'hFFFFFFFF;
		queue_matrix(m);
		drain();

		// With the directed results all arrived, queue one random matrix while the sender is held off.
		hold_send = 1'b1;
		queue_random_matrix();
		repeat (20) @(posedge clk);
		hold_send = 1'b0;

		// Random matrices over the idle and stall phases.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_pct[p][0];
			recv_stall_pct = phase_pct[p][1];
			for (int k = 0; k < 15; k++) queue_random_matrix();
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (200) @(posedge clk);

		$display("Sent %0d matrix rows, checked %0d inverse rows.", words_in, words_out);
		$display("Singular matrices: %0d, saturated elements: %0d.", singular_seen,
			sat_seen);
		if (errors == 0 && expected_inv.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/mi4_pkg.sv
src/mi4_if.sv
src/mi4_front.sv
src/mi4_fifo.sv
src/mi4_back.sv
src/matrix_inverse_4x4.sv
tb/tb_top.sv
